>>> rtl/core/ihp_pkg.sv
// Package for the indexed max-heap block: sizes, operation and status codes, entry type.
// It has no dependencies. The RAM, the compare unit and the top level import it.
package ihp_pkg;

    localparam int CAPACITY  = 256;
    localparam int NODE_BITS = 16;
    localparam int ADDR_W    = $clog2(CAPACITY);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int PRIO_W    = 32;

    localparam logic [2:0] KIND_PUSH  = 3'd0;
    localparam logic [2:0] KIND_POP   = 3'd1;
    localparam logic [2:0] KIND_DEC   = 3'd2;
    localparam logic [2:0] KIND_INC   = 3'd3;
    localparam logic [2:0] KIND_QUERY = 3'd4;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_IGN  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic signed [PRIO_W-1:0] prio;
        logic [NODE_BITS-1:0]     u;
        logic [NODE_BITS-1:0]     v;
    } t_entry;

    typedef struct packed {
        logic signed [PRIO_W-1:0] a;
        logic signed [PRIO_W-1:0] b;
        logic                     sub;
    } t_alu_req;

    typedef struct packed {
        logic signed [PRIO_W-1:0] sum;
        logic                     gt;
    } t_alu_rsp;

endpackage

>>> rtl/core/ihp_ram.sv
// Heap slot storage: one write port and one read port with registered read data.
// It depends on ihp_pkg for the entry type and address width.
module ihp_ram
    import ihp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  t_entry            i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output t_entry            o_rdata
);

    t_entry r_mem [CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> rtl/core/ihp_alu.sv
// Shared arithmetic unit: saturating add or subtract and a signed greater-than compare.
// It depends on ihp_pkg for the request and response types.
module ihp_alu
    import ihp_pkg::*;
(
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    logic signed [PRIO_W:0] w_ext;

    always_comb begin
        if (i_req.sub) begin
            w_ext = {i_req.a[PRIO_W-1], i_req.a} - {i_req.b[PRIO_W-1], i_req.b};
        end else begin
            w_ext = {i_req.a[PRIO_W-1], i_req.a} + {i_req.b[PRIO_W-1], i_req.b};
        end
        if (w_ext[PRIO_W] != w_ext[PRIO_W-1]) begin
            o_rsp.sum = w_ext[PRIO_W] ? {1'b1, {(PRIO_W-1){1'b0}}} : {1'b0, {(PRIO_W-1){1'b1}}};
        end else begin
            o_rsp.sum = w_ext[PRIO_W-1:0];
        end
        o_rsp.gt = (i_req.a > i_req.b);
    end

endmodule

>>> rtl/core/indexed_max_heap_pair_keys.sv
// Top level of the indexed max-heap with pair keys: sequencer, slot RAM and compare unit.
// It depends on ihp_pkg, ihp_ram and ihp_alu.
//
// Usage: an item (kind, priority or delta, node pair) enters on the input valid/ready
// channel and gives exactly one result on the output valid/ready channel. The result
// reports the root before the operation, whether the heap was empty, whether the pair
// was present, a status code and the fill level afterwards.
// Sequence: the root is read first, then a lookup compares one stored entry at a time
// until the pair is found or all entries are seen, then any sift runs, one level at a
// time: upward after a push or increase, downward after a pop or decrease. The lookup
// over the single RAM read port is the longest of these steps for a large heap.
// Only one item is in work at a time; input ready is high only when the sequencer is
// idle. A finished result waits in the output register while the receiver stalls, and
// the next item can be accepted meanwhile; it completes once that register is free.
// Synchronous reset empties the heap and drops any pending result; slot contents are
// not cleared since only slots below the fill level are ever read.
module indexed_max_heap_pair_keys
    import ihp_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [2:0]               i_kind,
    input  logic signed [PRIO_W-1:0] i_prio_or_delta,
    input  logic [NODE_BITS-1:0]     i_node_u,
    input  logic [NODE_BITS-1:0]     i_node_v,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [PRIO_W-1:0] o_top_prio,
    output logic [15:0]              o_top_u,
    output logic [15:0]              o_top_v,
    output logic                     o_was_empty,
    output logic                     o_pair_found,
    output logic [1:0]               o_status,
    output logic [8:0]               o_fill_level
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_TOP_RD   = 4'd1;
    localparam logic [3:0] S_TOP_CAP  = 4'd2;
    localparam logic [3:0] S_SCAN_RD  = 4'd3;
    localparam logic [3:0] S_SCAN_CMP = 4'd4;
    localparam logic [3:0] S_EXEC     = 4'd5;
    localparam logic [3:0] S_POP_CAP  = 4'd6;
    localparam logic [3:0] S_UP_RD    = 4'd7;
    localparam logic [3:0] S_UP_CMP   = 4'd8;
    localparam logic [3:0] S_DN_RDL   = 4'd9;
    localparam logic [3:0] S_DN_RDR   = 4'd10;
    localparam logic [3:0] S_DN_CMP   = 4'd11;
    localparam logic [3:0] S_DN_DEC   = 4'd12;
    localparam logic [3:0] S_FIN      = 4'd13;

    logic [3:0]               r_state, n_state;
    logic [2:0]               r_kind, n_kind;
    logic signed [PRIO_W-1:0] r_amt, n_amt;
    logic [NODE_BITS-1:0]     r_u, n_u, r_v, n_v;
    logic [CNT_W-1:0]         r_total, n_total;
    logic [CNT_W-1:0]         r_idx, n_idx;
    logic [ADDR_W-1:0]        r_pos, n_pos;
    logic [ADDR_W-1:0]        r_bidx, n_bidx;
    logic                     r_found, n_found;
    logic                     r_empty, n_empty;
    logic [1:0]               r_status, n_status;
    t_entry                   r_cur, n_cur;
    t_entry                   r_best, n_best;
    t_entry                   r_top, n_top;
    logic                     r_ov, n_ov;
    t_entry                   r_otop, n_otop;
    logic                     r_oempty, n_oempty;
    logic                     r_ofound, n_ofound;
    logic [1:0]               r_ostatus, n_ostatus;
    logic [CNT_W-1:0]         r_ofill, n_ofill;

    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    t_entry            w_wdata;
    logic [ADDR_W-1:0] w_raddr;
    t_entry            w_rdata;
    t_alu_req          w_req;
    t_alu_rsp          w_rsp;
    logic [CNT_W:0]    w_left;
    logic [CNT_W:0]    w_right;

    ihp_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    ihp_alu u_alu (
        .i_req (w_req),
        .o_rsp (w_rsp)
    );

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_ov;
    assign o_top_prio   = r_otop.prio;
    assign o_top_u      = r_otop.u;
    assign o_top_v      = r_otop.v;
    assign o_was_empty  = r_oempty;
    assign o_pair_found = r_ofound;
    assign o_status     = r_ostatus;
    assign o_fill_level = r_ofill;

    assign w_left  = {1'b0, r_pos, 1'b1};
    assign w_right = w_left + 1'b1;

    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        n_amt     = r_amt;
        n_u       = r_u;
        n_v       = r_v;
        n_total   = r_total;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_bidx    = r_bidx;
        n_found   = r_found;
        n_empty   = r_empty;
        n_status  = r_status;
        n_cur     = r_cur;
        n_best    = r_best;
        n_top     = r_top;
        n_ov      = r_ov;
        n_otop    = r_otop;
        n_oempty  = r_oempty;
        n_ofound  = r_ofound;
        n_ostatus = r_ostatus;
        n_ofill   = r_ofill;
        w_we      = 1'b0;
        w_waddr   = r_pos;
        w_wdata   = r_cur;
        w_raddr   = '0;
        w_req.a   = r_cur.prio;
        w_req.b   = r_amt;
        w_req.sub = (r_kind == KIND_DEC);

        if (r_ov && i_ready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_kind   = i_kind;
                    n_amt    = i_prio_or_delta;
                    n_u      = i_node_u;
                    n_v      = i_node_v;
                    n_found  = 1'b0;
                    n_status = ST_DONE;
                    n_idx    = '0;
                    n_empty  = (r_total == '0);
                    n_top    = '0;
                    n_state  = (r_total == '0) ? S_EXEC : S_TOP_RD;
                end
            end
            S_TOP_RD: begin
                n_state = S_TOP_CAP;
            end
            S_TOP_CAP: begin
                n_top   = w_rdata;
                n_state = S_SCAN_RD;
            end
            S_SCAN_RD: begin
                w_raddr = r_idx[ADDR_W-1:0];
                n_state = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (w_rdata.u == r_u && w_rdata.v == r_v) begin
                    n_found = 1'b1;
                    n_pos   = r_idx[ADDR_W-1:0];
                    n_cur   = w_rdata;
                    n_state = S_EXEC;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = (r_idx + 1'b1 == r_total) ? S_EXEC : S_SCAN_RD;
                end
            end
            S_EXEC: begin
                unique case (r_kind)
                    KIND_PUSH: begin
                        if (r_found) begin
                            n_status = ST_IGN;
                            n_state  = S_FIN;
                        end else if (r_total == CNT_W'(CAPACITY)) begin
                            n_status = ST_FULL;
                            n_state  = S_FIN;
                        end else begin
                            n_cur   = '{prio: r_amt, u: r_u, v: r_v};
                            n_pos   = r_total[ADDR_W-1:0];
                            n_total = r_total + 1'b1;
                            n_state = S_UP_RD;
                        end
                    end
                    KIND_POP: begin
                        if (r_empty) begin
                            n_status = ST_IGN;
                            n_state  = S_FIN;
                        end else begin
                            n_total = r_total - 1'b1;
                            n_pos   = '0;
                            w_raddr = n_total[ADDR_W-1:0];
                            n_state = (r_total == CNT_W'(1)) ? S_FIN : S_POP_CAP;
                        end
                    end
                    KIND_DEC, KIND_INC: begin
                        if (!r_found) begin
                            n_status = ST_IGN;
                            n_state  = S_FIN;
                        end else begin
                            n_cur.prio = w_rsp.sum;
                            n_state    = (r_kind == KIND_DEC) ? S_DN_RDL : S_UP_RD;
                        end
                    end
                    KIND_QUERY: begin
                        n_state = S_FIN;
                    end
                    default: begin
                        n_status = ST_IGN;
                        n_state  = S_FIN;
                    end
                endcase
            end
            S_POP_CAP: begin
                n_cur   = w_rdata;
                n_state = S_DN_RDL;
            end
            S_UP_RD: begin
                if (r_pos == '0) begin
                    w_we    = 1'b1;
                    n_state = S_FIN;
                end else begin
                    w_raddr = (r_pos - 1'b1) >> 1;
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                w_req.a = r_cur.prio;
                w_req.b = w_rdata.prio;
                w_we    = 1'b1;
                if (w_rsp.gt) begin
                    w_wdata = w_rdata;
                    n_pos   = (r_pos - 1'b1) >> 1;
                    n_state = S_UP_RD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DN_RDL: begin
                if (w_left >= {1'b0, r_total}) begin
                    w_we    = 1'b1;
                    n_state = S_FIN;
                end else begin
                    w_raddr = w_left[ADDR_W-1:0];
                    n_state = S_DN_RDR;
                end
            end
            S_DN_RDR: begin
                n_best = w_rdata;
                n_bidx = w_left[ADDR_W-1:0];
                if (w_right < {1'b0, r_total}) begin
                    w_raddr = w_right[ADDR_W-1:0];
                    n_state = S_DN_CMP;
                end else begin
                    n_state = S_DN_DEC;
                end
            end
            S_DN_CMP: begin
                w_req.a = w_rdata.prio;
                w_req.b = r_best.prio;
                if (w_rsp.gt) begin
                    n_best = w_rdata;
                    n_bidx = w_right[ADDR_W-1:0];
                end
                n_state = S_DN_DEC;
            end
            S_DN_DEC: begin
                w_req.a = r_best.prio;
                w_req.b = r_cur.prio;
                w_we    = 1'b1;
                if (w_rsp.gt) begin
                    w_wdata = r_best;
                    n_pos   = r_bidx;
                    n_state = S_DN_RDL;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_ov || i_ready) begin
                    n_ov      = 1'b1;
                    n_otop    = r_top;
                    n_oempty  = r_empty;
                    n_ofound  = r_found;
                    n_ostatus = r_status;
                    n_ofill   = r_total;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_total <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            r_ov    <= n_ov;
        end
        r_kind    <= n_kind;
        r_amt     <= n_amt;
        r_u       <= n_u;
        r_v       <= n_v;
        r_idx     <= n_idx;
        r_pos     <= n_pos;
        r_bidx    <= n_bidx;
        r_found   <= n_found;
        r_empty   <= n_empty;
        r_status  <= n_status;
        r_cur     <= n_cur;
        r_best    <= n_best;
        r_top     <= n_top;
        r_otop    <= n_otop;
        r_oempty  <= n_oempty;
        r_ofound  <= n_ofound;
        r_ostatus <= n_ostatus;
        r_ofill   <= n_ofill;
    end

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CNT_W'(CAPACITY))
        else $error("Entry count exceeds capacity.");

    a_full_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FULL) |-> (o_fill_level == CNT_W'(CAPACITY)))
        else $error("Full status reported below capacity.");

    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_was_empty) |-> (o_top_prio == '0 && o_top_u == '0 && o_top_v == '0))
        else $error("Empty heap reported a nonzero root.");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN_RD) |-> (r_idx < r_total))
        else $error("Lookup ran past the occupied slots.");

endmodule
